// File: design/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg: shared types and constants
// Sequencer states, arithmetic unit operations and request/response records
// for the postfix digit evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pde_pkg;

  // character codes
  localparam logic [7:0] CHAR_ADD = 8'h2B;
  localparam logic [7:0] CHAR_SUB = 8'h2D;
  localparam logic [7:0] CHAR_MUL = 8'h2A;
  localparam logic [7:0] CHAR_DIV = 8'h2F;

  // code of digit zero, and code read from an empty stack (-100)
  localparam logic [7:0] ZERO_CODE  = 8'd48;
  localparam logic [7:0] EMPTY_CODE = 8'h9C;

  // operand width: a signed byte code minus 48
  localparam int OPND_W = 9;

  // shift steps for multiply and divide
  localparam int ITER_STEPS = 8;
  localparam int STEP_W     = $clog2(ITER_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_RUN,
    ST_PUSH
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic                     start;
    alu_op_t                  op;
    logic signed [OPND_W-1:0] lhs;
    logic signed [OPND_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] code;
    logic       dz;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: design/pde_in_if.sv
// ----------------------------------------------------------------------------
// pde_in_if: character channel
// Valid/ready channel carrying one expression character per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       new_expression;

  modport source (output valid, output char_code, output new_expression, input ready);
  modport sink (input valid, input char_code, input new_expression, output ready);
endinterface

`default_nettype wire

// File: design/pde_out_if.sv
// ----------------------------------------------------------------------------
// pde_out_if: result channel
// Valid/ready channel carrying stack top, depth and event flags per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pde_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] top_code;
  logic [4:0]        depth;
  logic              overflow;
  logic              underflow;
  logic              divide_by_zero;

  modport source (output valid, output top_code, output depth, output overflow,
                  output underflow, output divide_by_zero, input ready);
  modport sink (input valid, input top_code, input depth, input overflow,
                input underflow, input divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: design/pde_alu.sv
// ----------------------------------------------------------------------------
// pde_alu: shared shift/add arithmetic unit
// One adder reused per step: single step add/subtract, shift-add multiply and
// restoring divide over eight steps; the result code then adds the zero code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pde_alu (
  input  logic              clk,
  input  logic              rst,
  input  pde_pkg::alu_req_t req,
  output pde_pkg::alu_rsp_t rsp
);

  logic                         busy;
  logic                         fin;
  logic [pde_pkg::STEP_W-1:0]   steps;
  pde_pkg::alu_op_t             mode;
  logic [8:0]                   acc;
  logic [7:0]                   a;
  logic [7:0]                   b;
  logic                         neg;
  logic                         dz;

  logic [8:0] x;
  logic [8:0] y;
  logic       sub;
  logic [9:0] sum;
  logic [8:0] lhs_mag;
  logic [8:0] rhs_mag;
  logic [7:0] div_val;
  logic [7:0] base;

  // operand magnitudes for the divider
  assign lhs_mag = req.lhs[8] ? 9'(-req.lhs) : req.lhs;
  assign rhs_mag = req.rhs[8] ? 9'(-req.rhs) : req.rhs;

  // shared adder operand selection
  always_comb begin
    x   = {1'b0, a};
    y   = {1'b0, b};
    sub = 1'b0;
    case (mode)
      pde_pkg::OP_ADD: begin
        x = {1'b0, a};
        y = {1'b0, b};
      end
      pde_pkg::OP_SUB: begin
        x   = {1'b0, a};
        y   = {1'b0, b};
        sub = 1'b1;
      end
      pde_pkg::OP_MUL: begin
        x = {1'b0, acc[7:0]};
        y = {1'b0, a};
      end
      pde_pkg::OP_DIV: begin
        x   = {acc[7:0], a[7]};
        y   = {1'b0, b};
        sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
  end

  // shared adder; bit 9 flags a borrow on subtraction
  assign sum = sub ? ({1'b0, x} - {1'b0, y}) : ({1'b0, x} + {1'b0, y});

  // sequencing and per step update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        mode <= req.op;
        acc  <= '0;
        neg  <= req.lhs[8] ^ req.rhs[8];
        dz   <= (req.op == pde_pkg::OP_DIV) && (req.rhs == '0);
        case (req.op)
          pde_pkg::OP_ADD, pde_pkg::OP_SUB: begin
            a     <= req.lhs[7:0];
            b     <= req.rhs[7:0];
            steps <= '0;
          end
          pde_pkg::OP_MUL: begin
            a     <= req.lhs[7:0];
            b     <= req.rhs[7:0];
            steps <= pde_pkg::STEP_W'(pde_pkg::ITER_STEPS - 1);
          end
          default: begin
            a     <= lhs_mag[7:0];
            b     <= rhs_mag[7:0];
            steps <= pde_pkg::STEP_W'(pde_pkg::ITER_STEPS - 1);
          end
        endcase
      end else if (busy) begin
        case (mode)
          pde_pkg::OP_ADD, pde_pkg::OP_SUB: begin
            acc <= sum[8:0];
          end
          pde_pkg::OP_MUL: begin
            if (b[0]) begin
              acc <= sum[8:0];
            end
            a <= {a[6:0], 1'b0};
            b <= {1'b0, b[7:1]};
          end
          default: begin
            if (!sum[9]) begin
              acc <= sum[8:0];
              a   <= {a[6:0], 1'b1};
            end else begin
              acc <= x;
              a   <= {a[6:0], 1'b0};
            end
          end
        endcase
        if (steps == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          steps <= steps - 1'b1;
          fin   <= 1'b0;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  // result code: signed quotient or low byte of the sum, plus the zero code
  assign div_val = dz ? 8'd0 : (neg ? 8'(~a + 8'd1) : a);
  assign base    = (mode == pde_pkg::OP_DIV) ? div_val : acc[7:0];

  assign rsp.done = fin;
  assign rsp.code = base + pde_pkg::ZERO_CODE;
  assign rsp.dz   = dz;

endmodule

`default_nettype wire

// File: design/postfix_digit_evaluator.sv
// Flow: a plain character goes from acceptance straight to the push state;
// an operator passes fetch, load and run first, * and / with eight shift steps.
// The one-item sequencer and the shared arithmetic unit take no new item until
// the last one is pushed; the stack read below the top is registered.
// A waiting result does not block acceptance of the next item.
// Reset (synchronous, active high) empties the stack; no clearing pass.
// ----------------------------------------------------------------------------
// postfix_digit_evaluator: postfix expression evaluator
// Byte stack in a memory, a sequencer that pops operands, drives the shared
// arithmetic unit and pushes the result, reporting top and depth per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module postfix_digit_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  pde_in_if.sink     symbols,
  pde_out_if.source  results
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  pde_pkg::state_t   state;
  pde_pkg::state_t   state_next;
  pde_pkg::alu_req_t alu_req;
  pde_pkg::alu_rsp_t alu_rsp;
  pde_pkg::alu_op_t  op_sel;

  logic [7:0]    stack_mem [STACK_DEPTH];
  logic [7:0]    rd_data;
  logic [CW-1:0] count;
  logic [7:0]    top;
  logic [7:0]    ch;
  logic [7:0]    push_val;
  logic [7:0]    rhs_code;
  logic          under;
  logic          dz;

  logic          accept;
  logic          in_is_op;
  logic          slot_free;
  logic          full;
  logic [CW-1:0] eff_count;
  logic [CW-1:0] below2;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count_after;
  logic [CW+4:0] depth_ext;
  logic [7:0]    lhs_code;

  // handshake and stack pointers
  assign accept      = symbols.valid && symbols.ready;
  assign slot_free   = !results.valid || results.ready;
  assign full        = (count >= FULL);
  assign eff_count   = symbols.new_expression ? '0 : count;
  assign below2      = count - TWO;
  assign rd_addr     = below2[AW-1:0];
  assign count_after = full ? count : count + ONE;
  assign depth_ext   = {5'd0, count_after};
  assign lhs_code    = (count >= TWO) ? rd_data : pde_pkg::EMPTY_CODE;

  // operator detection on the incoming character
  always_comb begin
    case (symbols.char_code)
      pde_pkg::CHAR_ADD, pde_pkg::CHAR_SUB,
      pde_pkg::CHAR_MUL, pde_pkg::CHAR_DIV: in_is_op = 1'b1;
      default:                              in_is_op = 1'b0;
    endcase
  end

  // operation select from the held character
  always_comb begin
    case (ch)
      pde_pkg::CHAR_SUB: op_sel = pde_pkg::OP_SUB;
      pde_pkg::CHAR_MUL: op_sel = pde_pkg::OP_MUL;
      pde_pkg::CHAR_DIV: op_sel = pde_pkg::OP_DIV;
      default:           op_sel = pde_pkg::OP_ADD;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pde_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = in_is_op ? pde_pkg::ST_FETCH : pde_pkg::ST_PUSH;
        end
      end
      pde_pkg::ST_FETCH: state_next = pde_pkg::ST_LOAD;
      pde_pkg::ST_LOAD:  state_next = pde_pkg::ST_RUN;
      pde_pkg::ST_RUN: begin
        if (alu_rsp.done) begin
          state_next = pde_pkg::ST_PUSH;
        end
      end
      pde_pkg::ST_PUSH: begin
        if (slot_free) begin
          state_next = pde_pkg::ST_IDLE;
        end
      end
      default: state_next = pde_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    symbols.ready = (state == pde_pkg::ST_IDLE);
    alu_req.start = (state == pde_pkg::ST_LOAD);
    alu_req.op    = op_sel;
    alu_req.lhs   = $signed({lhs_code[7], lhs_code}) - 9'sd48;
    alu_req.rhs   = $signed({rhs_code[7], rhs_code}) - 9'sd48;
  end

  pde_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // stack memory: push write, registered read below the top
  always_ff @(posedge clk) begin
    if (state == pde_pkg::ST_PUSH && slot_free && !full) begin
      stack_mem[count[AW-1:0]] <= push_val;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pde_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stack control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (state == pde_pkg::ST_PUSH && slot_free) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        pde_pkg::ST_IDLE: begin
          if (accept) begin
            ch       <= symbols.char_code;
            push_val <= symbols.char_code;
            count    <= eff_count;
            under    <= 1'b0;
            dz       <= 1'b0;
            rhs_code <= (eff_count != '0) ? top : pde_pkg::EMPTY_CODE;
          end
        end
        pde_pkg::ST_LOAD: begin
          // both operands popped, short stack flags underflow
          under <= (count < TWO);
          count <= (count >= TWO) ? below2 : '0;
        end
        pde_pkg::ST_RUN: begin
          if (alu_rsp.done) begin
            push_val <= alu_rsp.code;
            dz       <= alu_rsp.dz;
          end
        end
        pde_pkg::ST_PUSH: begin
          if (slot_free) begin
            if (!full) begin
              top   <= push_val;
              count <= count_after;
            end
            results.top_code       <= $signed(full ? top : push_val);
            results.depth          <= depth_ext[4:0];
            results.overflow       <= full;
            results.underflow      <= under;
            results.divide_by_zero <= dz;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // stack count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("stack count beyond capacity");

  // a finished operation always moves on to the push
  a_run_to_push: assert property (@(posedge clk) disable iff (rst)
    state == pde_pkg::ST_RUN && alu_rsp.done |=> state == pde_pkg::ST_PUSH)
    else $error("operation result not pushed");

  // overflow only on plain characters, never with operator flags
  a_flag_mix: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.overflow && (results.underflow || results.divide_by_zero)))
    else $error("overflow reported with operator flags");

  // a start of the arithmetic unit is followed by the run state, with no second start
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |=> !alu_req.start && state == pde_pkg::ST_RUN)
    else $error("arithmetic unit restarted");

endmodule

`default_nettype wire

// File: tb/postfix_digit_evaluator_tb.sv
// ----------------------------------------------------------------------------
// postfix_digit_evaluator_tb: self-checking bench for the postfix evaluator
// Drives expression characters over the valid/ready input channel, keeps its
// own byte-stack model to predict top, depth and event flags per character,
// and checks every result in order. Directed extremes first, then random
// postfix expressions, noise, back-pressure, a no-idle burst and drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_digit_evaluator_tb;

  localparam int STACK_DEPTH = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 36;

  // one expected stack report
  typedef struct packed {
    logic [7:0] top_code;
    logic [4:0] depth;
    logic       overflow;
    logic       underflow;
    logic       divide_by_zero;
  } stack_report_t;

  logic clk;
  logic rst;

  pde_in_if  sym_if ();
  pde_out_if res_if ();

  postfix_digit_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_if),
    .results (res_if)
  );

  // stack model and expected reports
  logic signed [7:0] model_stack [STACK_DEPTH];
  int                model_count;
  stack_report_t     pending_reports [$];
  stack_report_t     want_report;

  // run state and statistics
  int   cycle_count;
  int   err_count;
  int   sent_items;
  int   checked_reports;
  int   op_items;
  int   overflow_seen;
  int   underflow_seen;
  int   div_zero_seen;
  logic src_idle_on;
  logic snk_idle_on;
  logic hold_sink;
  int   hold_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("FAIL postfix_digit_evaluator");
    $finish;
  end

  function automatic logic is_operator(input logic [7:0] ch);
    return ch == pde_pkg::CHAR_ADD || ch == pde_pkg::CHAR_SUB ||
           ch == pde_pkg::CHAR_MUL || ch == pde_pkg::CHAR_DIV;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0: return pde_pkg::CHAR_ADD;
      1: return pde_pkg::CHAR_SUB;
      2: return pde_pkg::CHAR_MUL;
      default: return pde_pkg::CHAR_DIV;
    endcase
  endfunction

  // pop one operand: stored code minus the zero digit, an empty stack reads as code -100
  function automatic int pop_operand(inout logic under);
    int code;
    if (model_count == 0) begin
      under = 1'b1;
      code  = $signed(pde_pkg::EMPTY_CODE);
    end else begin
      model_count--;
      code = model_stack[model_count];
    end
    return code - int'(pde_pkg::ZERO_CODE);
  endfunction

  // push a code truncated to a byte, dropped when the stack is full
  function automatic void push_code(input int code, inout logic over);
    if (model_count >= STACK_DEPTH) begin
      over = 1'b1;
    end else begin
      model_stack[model_count] = code[7:0];
      model_count++;
    end
  endfunction

  // predict the report for one accepted character
  function automatic stack_report_t evaluate_char(input logic [7:0] ch, input logic nx);
    stack_report_t rep;
    logic          over;
    logic          under;
    logic          dz;
    int            lhs;
    int            rhs;
    int            res;
    over  = 1'b0;
    under = 1'b0;
    dz    = 1'b0;
    if (nx) begin
      model_count = 0;
    end
    if (is_operator(ch)) begin
      rhs = pop_operand(under);
      lhs = pop_operand(under);
      case (ch)
        pde_pkg::CHAR_ADD: res = lhs + rhs;
        pde_pkg::CHAR_SUB: res = lhs - rhs;
        pde_pkg::CHAR_MUL: res = lhs * rhs;
        default: begin
          // division by zero gives the zero digit, otherwise truncate towards zero
          if (rhs == 0) begin
            dz  = 1'b1;
            res = 0;
          end else begin
            res = lhs / rhs;
          end
        end
      endcase
      push_code(res + int'(pde_pkg::ZERO_CODE), over);
    end else begin
      push_code(int'(ch), over);
    end
    rep.top_code       = (model_count == 0) ? pde_pkg::EMPTY_CODE :
                         model_stack[model_count - 1];
    rep.depth          = 5'(model_count);
    rep.overflow       = over;
    rep.underflow      = under;
    rep.divide_by_zero = dz;
    return rep;
  endfunction

  // offer one character, wait for the handshake, then record its expected report
  task automatic send_char(input logic [7:0] ch, input logic nx);
    stack_report_t rep;
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      sym_if.valid <= 1'b0;
      @(posedge clk);
    end
    sym_if.valid          <= 1'b1;
    sym_if.char_code      <= ch;
    sym_if.new_expression <= nx;
    do @(posedge clk); while (!sym_if.ready);
    rep = evaluate_char(ch, nx);
    pending_reports.push_back(rep);
    sent_items++;
    if (is_operator(ch)) op_items++;
    if (rep.overflow) overflow_seen++;
    if (rep.underflow) underflow_seen++;
    if (rep.divide_by_zero) div_zero_seen++;
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_results_drained();
    sym_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // well-formed postfix expression with random operands and operators
  task automatic send_expression(input int operand_total, input logic operands_first);
    int         pushed;
    int         level;
    logic       first;
    logic [7:0] ch;
    pushed = 0;
    level  = 0;
    first  = 1'b1;
    while (pushed < operand_total || level > 1) begin
      if (pushed < operand_total &&
          (level < 2 || operands_first || $urandom_range(1) == 0)) begin
        if ($urandom_range(99) < 85) begin
          ch = 8'(pde_pkg::ZERO_CODE + 8'($urandom_range(9)));
        end else begin
          ch = 8'($urandom_range(255));
          if (is_operator(ch)) ch = pde_pkg::ZERO_CODE;
        end
        pushed++;
        level++;
      end else begin
        ch = pick_operator();
        level--;
      end
      send_char(ch, first);
      first = 1'b0;
    end
  endtask

  // fill the stack with extreme codes, all digits and two more characters, then push once more
  task automatic test_fill_and_overflow();
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
    for (int d = 0; d < 10; d++) begin
      send_char(8'(pde_pkg::ZERO_CODE + 8'(d)), 1'b0);
    end
    send_char(" ", 1'b0);
    send_char("a", 1'b0);
    send_char("9", 1'b0);
  endtask

  // every operator, starting on the full stack, results out of byte range included
  task automatic test_operator_chain();
    send_char(pde_pkg::CHAR_MUL, 1'b0);
    send_char(pde_pkg::CHAR_DIV, 1'b0);
    send_char(pde_pkg::CHAR_SUB, 1'b0);
    send_char(pde_pkg::CHAR_ADD, 1'b0);
  endtask

  // zero divisor, operator on an empty stack, operator with one operand
  task automatic test_zero_divisor_and_underflow();
    send_char("0", 1'b0);
    send_char(pde_pkg::CHAR_DIV, 1'b0);
    send_char(pde_pkg::CHAR_ADD, 1'b1);
    send_char("5", 1'b1);
    send_char(pde_pkg::CHAR_SUB, 1'b0);
  endtask

  // mostly short expressions, a few deep ones that can run past capacity
  task automatic test_random_expressions(input int target);
    int start;
    start = sent_items;
    while (sent_items - start < target) begin
      if ($urandom_range(19) == 0) begin
        send_expression($urandom_range(15, 18), 1'b1);
      end else begin
        send_expression($urandom_range(1, 8), 1'b0);
      end
    end
  endtask

  // random bytes and operators with occasional restarts
  task automatic test_noise(input int count);
    logic [7:0] ch;
    repeat (count) begin
      ch = ($urandom_range(2) == 0) ? pick_operator() : 8'($urandom_range(255));
      send_char(ch, $urandom_range(7) == 0);
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_sink_hold();
    hold_sink = 1'b1;
    repeat (6) send_expression($urandom_range(2, 5), 1'b0);
    wait_results_drained();
  endtask

  // stretch with no idling on either side
  task automatic test_no_idle_burst(input int target);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_random_expressions(target);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // sender pauses until every result is back
  task automatic test_drain_pauses();
    repeat (4) begin
      send_expression($urandom_range(1, 6), 1'b0);
      wait_results_drained();
    end
  endtask

  // result receiver: random stalls and a counted hold-off
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink && hold_count < HOLD_CYCLES) begin
        res_if.ready <= 1'b0;
        hold_count++;
      end else begin
        if (hold_sink) begin
          hold_sink  = 1'b0;
          hold_count = 0;
        end
        res_if.ready <= !(snk_idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      err_count++;
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual top %0d depth %0d",
                 $time, res_if.top_code, res_if.depth);
        err_count++;
      end else begin
        want_report = pending_reports.pop_front();
        check_field("top_code", $signed(want_report.top_code), res_if.top_code);
        check_field("depth", want_report.depth, res_if.depth);
        check_field("overflow", want_report.overflow, res_if.overflow);
        check_field("underflow", want_report.underflow, res_if.underflow);
        check_field("divide_by_zero", want_report.divide_by_zero, res_if.divide_by_zero);
        checked_reports++;
      end
    end
  end

  // test sequence
  initial begin
    err_count       = 0;
    sent_items      = 0;
    checked_reports = 0;
    op_items        = 0;
    overflow_seen   = 0;
    underflow_seen  = 0;
    div_zero_seen   = 0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    hold_sink       = 1'b0;
    hold_count      = 0;
    model_count     = 0;
    rst                   <= 1'b1;
    sym_if.valid          <= 1'b0;
    sym_if.char_code      <= 8'h00;
    sym_if.new_expression <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_and_overflow();
    test_operator_chain();
    test_zero_divisor_and_underflow();
    test_random_expressions(800);
    test_noise(270);
    test_sink_hold();
    test_no_idle_burst(80);
    test_drain_pauses();

    // drain and allow for any stray result
    wait_results_drained();
    repeat (20) @(posedge clk);

    $display("run covered %0d characters (%0d operators), %0d results checked",
             sent_items, op_items, checked_reports);
    $display("events: %0d overflows, %0d underflows, %0d zero divisors, %0d errors",
             overflow_seen, underflow_seen, div_zero_seen, err_count);
    if (err_count == 0) begin
      $display("PASS postfix_digit_evaluator");
    end else begin
      $display("FAIL postfix_digit_evaluator");
    end
    $finish;
  end

endmodule
